>>> sv/integer_to_radix_text_macros.svh
// ---------------------------------------------------------------------------
// Integer to radix text: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define R2T_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause
`define R2T_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/r2t_pkg.sv
// ---------------------------------------------------------------------------
// Integer to radix text: package
// Widths, codes, control types and digit helpers shared by the block.
// ---------------------------------------------------------------------------
package r2t_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int NUM_CELLS   = VALUE_WIDTH;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + NUM_CELLS);
	localparam int NCNT_W      = $clog2(NUM_CELLS + 1);
	localparam int BCNT_W      = $clog2(VALUE_WIDTH + 1);
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int LEN_W       = 7;
	localparam int RADIX_W     = 6;

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
	localparam logic [DIGIT_W-1:0] DEC_BASE  = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0]  CHAR_LOW_A = CHAR_W'(8'h61);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	// Commands to the digit row
	typedef struct packed {
		logic clear;
		logic conv;
		logic shift;
	} row_ctl_t;

	function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
		return (r >= RADIX_MIN) && (r <= RADIX_MAX);
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d < DEC_BASE)
			return CHAR_ZERO + dx;
		else
			return CHAR_LOW_A + dx - CHAR_W'(DEC_BASE);
	endfunction

endpackage

>>> sv/r2t_feed.sv
// ---------------------------------------------------------------------------
// Integer to radix text: magnitude feed
// Takes the magnitude of the input and shifts it out MSB first, one bit a
// cycle while advance is high; a valid flag marks the bits still to come.
// ---------------------------------------------------------------------------
module r2t_feed
	import r2t_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic                   advance,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   is_signed,
	output logic                   neg,
	output logic                   bit_out,
	output logic                   bit_en
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCNT_W-1:0]      left_q;
	logic                   neg_q;
	logic                   neg_in;
	logic [VALUE_WIDTH-1:0] mag_in;

	// Negate a negative signed value; the most negative one maps to itself
	always_comb begin
		neg_in = is_signed & value[VALUE_WIDTH-1];
		mag_in = neg_in ? (~value + VALUE_WIDTH'(1)) : value;
	end

	// Count the bits still to send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			neg_q  <= 1'b0;
		end else if (load) begin
			left_q <= BCNT_W'(VALUE_WIDTH);
			neg_q  <= neg_in;
		end else if (advance && (left_q != '0)) begin
			left_q <= left_q - BCNT_W'(1);
		end
	end

	// Hold the magnitude and shift it out MSB first
	always_ff @(posedge clk) begin
		if (load)
			mag_q <= mag_in;
		else if (advance)
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
	end

	assign neg     = neg_q;
	assign bit_out = mag_q[VALUE_WIDTH-1];
	assign bit_en  = advance && (left_q != '0);

endmodule

>>> sv/r2t_digit_row.sv
// ---------------------------------------------------------------------------
// Integer to radix text: digit row
// A row of radix digit cells, least significant at index 0. Each cell
// doubles its digit and adds the carry of its lower neighbor; while conv is
// commanded, carries and enables pass one cell per cycle, so the bit stream
// ripples up as a wave. Afterwards the row shifts toward the top, one digit a cycle while shift is commanded.
// ---------------------------------------------------------------------------
module r2t_digit_row
	import r2t_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  row_ctl_t           ctl,
	input  logic [RADIX_W-1:0] radix,
	input  logic               bit_in,
	input  logic               bit_en,
	output logic [DIGIT_W-1:0] top_digit
);

	logic [DIGIT_W-1:0]   d_q [NUM_CELLS];
	logic [NUM_CELLS-1:0] en_q;
	logic [NUM_CELLS-1:0] c_q;
	logic [NUM_CELLS-1:0] act;
	logic [NUM_CELLS-1:0] cin;
	logic [NUM_CELLS-1:0] cout;
	logic [DIGIT_W-1:0]   nd [NUM_CELLS];
	logic [DIGIT_W-1:0]   up [NUM_CELLS];

	// Step every cell: digit = 2 * digit + carry in, reduced once by radix
	always_comb begin
		logic [DIGIT_W:0] s;
		act = {en_q[NUM_CELLS-2:0], bit_en};
		cin = {c_q[NUM_CELLS-2:0], bit_in};
		for (int i = 0; i < NUM_CELLS; i++) begin
			s = {d_q[i], 1'b0} + (DIGIT_W+1)'(cin[i]);
			cout[i] = (s >= (DIGIT_W+1)'(radix));
			nd[i] = cout[i] ? DIGIT_W'(s - (DIGIT_W+1)'(radix)) : s[DIGIT_W-1:0];
		end
	end

	// Form the row moved up by one digit
	always_comb begin
		up[0] = '0;
		for (int i = 1; i < NUM_CELLS; i++)
			up[i] = d_q[i-1];
	end

	// Advance the enable and carry wave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			c_q  <= '0;
		end else if (ctl.clear) begin
			en_q <= '0;
			c_q  <= '0;
		end else if (ctl.conv) begin
			en_q <= act;
			c_q  <= act & cout;
		end
	end

	// Update the digits
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CELLS; i++) begin
			if (ctl.clear)
				d_q[i] <= '0;
			else if (ctl.conv && act[i])
				d_q[i] <= nd[i];
			else if (ctl.shift)
				d_q[i] <= up[i];
		end
	end

	assign top_digit = d_q[NUM_CELLS-1];

endmodule

>>> sv/integer_to_radix_text.sv
// ---------------------------------------------------------------------------
// Integer to radix text
// Converts a 64-bit integer to ASCII digits in radix 2 to 36, MSB first.
// ---------------------------------------------------------------------------
// Usage: drive value, is_signed and radix with start high; the item is
// taken at a rising edge where start is high and busy is low.
// Results come out one character per cycle, each marked by strobe for one
// cycle; the receiver cannot stall them and must take every one.
// A bad radix gives one error result the cycle after the transfer and busy
// stays low, so another item may follow at once.
// A valid item keeps busy high while the bit wave of 64 bits crosses the
// 64-cell digit row, then while the row shifts up one digit a cycle, first
// dropping leading zeros and then sending each digit. Results are registered
// and appear in the cycle after their shift, so the last result shows in the
// cycle after busy falls.
// A negative value sets lead_minus on the first character; the last one
// carries the text length including the sign.
// Reset clears the controller and the carry wave; no result is pending.
// ---------------------------------------------------------------------------
`include "integer_to_radix_text_macros.svh"

module integer_to_radix_text
	import r2t_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [63:0]        value,
	input  logic               is_signed,
	input  logic [RADIX_W-1:0] radix,
	output logic               strobe,
	output logic [CHAR_W-1:0]  text_char,
	output logic               lead_minus,
	output logic               is_last,
	output logic [LEN_W-1:0]   text_length,
	output logic               radix_error
);

	localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_WIDTH + NUM_CELLS - 2);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [NCNT_W-1:0]  n_q;
	logic               first_q;
	logic [LEN_W-1:0]   len_q;
	logic [RADIX_W-1:0] radix_q;
	logic               strobe_q;
	logic [CHAR_W-1:0]  char_q;
	logic               minus_q;
	logic               last_q;
	logic [LEN_W-1:0]   tlen_q;
	logic               err_q;

	logic               accept;
	logic               load;
	logic               bad;
	logic               emit_now;
	logic               neg;
	logic               feed_bit;
	logic               feed_en;
	logic [DIGIT_W-1:0] top_digit;
	logic [LEN_W-1:0]   total_len;
	row_ctl_t           row_ctl;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign load   = accept && radix_ok(radix);
	assign bad    = accept && !radix_ok(radix);

	r2t_feed u_feed (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.advance   (state_q == ST_CONV),
		.value     (value[VALUE_WIDTH-1:0]),
		.is_signed (is_signed),
		.neg       (neg),
		.bit_out   (feed_bit),
		.bit_en    (feed_en)
	);

	r2t_digit_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (row_ctl),
		.radix     (radix_q),
		.bit_in    (feed_bit),
		.bit_en    (feed_en),
		.top_digit (top_digit)
	);

	// Next state and row commands
	always_comb begin
		state_d       = state_q;
		row_ctl.clear = load;
		row_ctl.conv  = (state_q == ST_CONV);
		row_ctl.shift = (state_q == ST_EMIT);
		emit_now      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (load)
					state_d = ST_CONV;
			end
			ST_CONV: begin
				if (cnt_q == CONV_LAST)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit_now = !(first_q && (top_digit == '0) && (n_q > NCNT_W'(1)));
				if (n_q == NCNT_W'(1))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign total_len = LEN_W'(n_q) + LEN_W'(neg);

	// Hold state, cycle and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			n_q      <= '0;
			first_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= bad || emit_now;
			if (load) begin
				cnt_q   <= '0;
				n_q     <= NCNT_W'(NUM_CELLS);
				first_q <= 1'b1;
			end else begin
				if (state_q == ST_CONV)
					cnt_q <= cnt_q + CNT_W'(1);
				if (state_q == ST_EMIT)
					n_q <= n_q - NCNT_W'(1);
				if (emit_now)
					first_q <= 1'b0;
			end
		end
	end

	// Register radix, length and the result payload
	always_ff @(posedge clk) begin
		if (load)
			radix_q <= radix;
		if (emit_now && first_q)
			len_q <= total_len;
		if (bad) begin
			char_q  <= '0;
			minus_q <= 1'b0;
			last_q  <= 1'b1;
			tlen_q  <= '0;
			err_q   <= 1'b1;
		end else if (emit_now) begin
			char_q  <= digit_char(top_digit);
			minus_q <= neg && first_q;
			last_q  <= (n_q == NCNT_W'(1));
			if (n_q == NCNT_W'(1))
				tlen_q <= first_q ? total_len : len_q;
			else
				tlen_q <= '0;
			err_q   <= 1'b0;
		end
	end

	assign strobe      = strobe_q;
	assign text_char   = char_q;
	assign lead_minus  = minus_q;
	assign is_last     = last_q;
	assign text_length = tlen_q;
	assign radix_error = err_q;

	`R2T_ASSERT_SAME(a_err_single, strobe_q && err_q, last_q && (tlen_q == '0) && !minus_q, "error item must be a lone last item")
	`R2T_ASSERT_SAME(a_last_len, strobe_q && last_q && !err_q, tlen_q != '0, "last character must carry a length")
	`R2T_ASSERT_SAME(a_digit_range, state_q == ST_EMIT, top_digit < DIGIT_W'(radix_q), "digit out of radix range")
	`R2T_ASSERT_NEXT(a_conv_done, (state_q == ST_CONV) && (cnt_q == CONV_LAST), (state_q == ST_EMIT) && (n_q == NCNT_W'(NUM_CELLS)), "conversion must hand a full row to emit")

endmodule

>>> dv/tb.sv
// ---------------------------------------------------------------------------
// Integer to radix text: testbench
// Sends a table of directed numbers (zero, all ones, the most negative
// value, bad radices, single and two-digit results), then random numbers in
// random radices, with random gaps on the sender side. Each character that
// comes out is compared, field by field, with the expected text. That text
// is either typed into the table or worked out by a local radix converter.
// ---------------------------------------------------------------------------
module tb;
	import r2t_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              minus;
		logic              last;
		logic [LEN_W-1:0]  len;
		logic              err;
	} digit_item_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TEXT,
		ROW_BAD_RADIX
	} row_kind_t;

	typedef struct {
		logic [63:0]        val;
		logic               sgn;
		logic [RADIX_W-1:0] rdx;
		row_kind_t          kind;
		string              text;
	} stim_row_t;

	localparam digit_item_t RADIX_FAULT = '{ch: '0, minus: 1'b0, last: 1'b1,
		len: '0, err: 1'b1};
	localparam int RANDOM_ITEMS = 470;
	localparam int DRAIN_CYCLES = 200;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [63:0]        value;
	logic               is_signed;
	logic [RADIX_W-1:0] radix;
	logic               strobe;
	logic [CHAR_W-1:0]  text_char;
	logic               lead_minus;
	logic               is_last;
	logic [LEN_W-1:0]   text_length;
	logic               radix_error;

	digit_item_t digits_due[$];
	digit_item_t want;
	stim_row_t   rows[$];
	int          mismatch_count = 0;
	bit          idle_on = 1'b1;

	integer_to_radix_text uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.is_signed   (is_signed),
		.radix       (radix),
		.strobe      (strobe),
		.text_char   (text_char),
		.lead_minus  (lead_minus),
		.is_last     (is_last),
		.text_length (text_length),
		.radix_error (radix_error)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Print one mismatch line and count it
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, exp_val);
		mismatch_count++;
	endtask

	// Convert a number to its text in the given radix, minus sign in front
	function automatic string radix_text(input logic [63:0] v, input logic sgn,
			input logic [RADIX_W-1:0] r);
		string       digit_set;
		string       txt;
		logic [63:0] mag;
		int          d;
		digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
		txt = "";
		// Negating the most negative value wraps to 2^63, its true magnitude
		mag = (sgn && v[63]) ? -v : v;
		do begin
			d = int'(mag % 64'(r));
			txt = {digit_set.substr(d, d), txt};
			mag = mag / 64'(r);
		end while (mag != 64'd0);
		if (sgn && v[63])
			txt = {"-", txt};
		return txt;
	endfunction

	// Queue one character transfer per digit of the text
	function automatic void expect_text(input string txt);
		int          first;
		digit_item_t item;
		first = (txt[0] == "-") ? 1 : 0;
		for (int i = first; i < txt.len(); i++) begin
			item.ch    = CHAR_W'(txt[i]);
			item.minus = (first == 1) && (i == first);
			item.last  = (i == txt.len() - 1);
			item.len   = item.last ? LEN_W'(txt.len()) : '0;
			item.err   = 1'b0;
			digits_due.push_back(item);
		end
	endfunction

	task automatic add_row(input logic [63:0] v, input logic sgn, input int r,
			input row_kind_t kind, input string txt = "");
		stim_row_t row;
		row.val  = v;
		row.sgn  = sgn;
		row.rdx  = RADIX_W'(r);
		row.kind = kind;
		row.text = txt;
		rows.push_back(row);
	endtask

	// Offer one number, hold it until the transfer, then queue its text
	task automatic send_item(input stim_row_t row);
		if (idle_on && $urandom_range(0, 99) < 28) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 28);
		end
		start     <= 1'b1;
		value     <= row.val;
		is_signed <= row.sgn;
		radix     <= row.rdx;
		do @(posedge clk); while (busy !== 1'b0);
		case (row.kind)
			ROW_TEXT: begin
				expect_text(row.text);
			end
			ROW_BAD_RADIX: begin
				digits_due.push_back(RADIX_FAULT);
			end
			default: begin
				if (row.rdx < RADIX_MIN || row.rdx > RADIX_MAX)
					digits_due.push_back(RADIX_FAULT);
				else
					expect_text(radix_text(row.val, row.sgn, row.rdx));
			end
		endcase
	endtask

	// Drop start and wait until every queued character has come out
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (digits_due.size() != 0);
	endtask

	function automatic logic [63:0] rand_value();
		logic [63:0] full;
		full = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0:       return 64'($urandom_range(0, 40));
			1:       return 64'($urandom_range(0, 100000));
			2, 3:    return full >> $urandom_range(0, 63);
			4:       return {1'b1, 63'($urandom_range(0, 50))};
			5:       return 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 50));
			6:       return ~64'($urandom_range(0, 50));
			default: return full;
		endcase
	endfunction

	function automatic logic [RADIX_W-1:0] rand_radix();
		case ($urandom_range(0, 19))
			0:       return RADIX_MIN;
			1:       return RADIX_MAX;
			2, 3, 4: return RADIX_W'($urandom_range(0, 63));
			default: return RADIX_W'($urandom_range(2, 36));
		endcase
	endfunction

	// Check each character transfer against the oldest expected one
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (digits_due.size() == 0) begin
				report_mismatch("character with none expected", 64'(text_char), 64'd0);
			end else begin
				want = digits_due.pop_front();
				if (text_char !== want.ch)
					report_mismatch("text_char", 64'(text_char), 64'(want.ch));
				if (lead_minus !== want.minus)
					report_mismatch("lead_minus", 64'(lead_minus), 64'(want.minus));
				if (is_last !== want.last)
					report_mismatch("is_last", 64'(is_last), 64'(want.last));
				if (text_length !== want.len)
					report_mismatch("text_length", 64'(text_length), 64'(want.len));
				if (radix_error !== want.err)
					report_mismatch("radix_error", 64'(radix_error), 64'(want.err));
			end
		end
	end

	initial begin
		stim_row_t row;
		arst_n    = 1'b0;
		start     = 1'b0;
		value     = '0;
		is_signed = 1'b0;
		radix     = '0;

		// Directed table: zero, extremes, edge radices, error radices
		add_row(64'd0, 1'b0, 10, ROW_TEXT, "0");
		add_row(64'd0, 1'b1, 2, ROW_TEXT, "0");
		add_row(64'hffff_ffff_ffff_ffff, 1'b0, 16, ROW_TEXT, "ffffffffffffffff");
		add_row(64'hffff_ffff_ffff_ffff, 1'b1, 10, ROW_TEXT, "-1");
		add_row(64'hffff_ffff_ffff_ffff, 1'b1, 36, ROW_TEXT, "-1");
		add_row(64'h8000_0000_0000_0000, 1'b1, 10, ROW_TEXT, "-9223372036854775808");
		add_row(64'h8000_0000_0000_0000, 1'b0, 16, ROW_TEXT, "8000000000000000");
		add_row(64'h7fff_ffff_ffff_ffff, 1'b1, 16, ROW_TEXT, "7fffffffffffffff");
		add_row(64'd35, 1'b0, 36, ROW_TEXT, "z");
		add_row(64'd36, 1'b0, 36, ROW_TEXT, "10");
		add_row(64'd255, 1'b0, 16, ROW_TEXT, "ff");
		add_row(64'd10, 1'b1, 10, ROW_TEXT, "10");
		add_row(-64'd10, 1'b1, 10, ROW_TEXT, "-10");
		add_row(64'd1, 1'b1, 3, ROW_TEXT, "1");
		add_row(64'd5, 1'b0, 2, ROW_TEXT, "101");
		add_row(64'd0, 1'b0, 0, ROW_BAD_RADIX);
		add_row(64'hffff_ffff_ffff_ffff, 1'b1, 1, ROW_BAD_RADIX);
		add_row(64'd12345, 1'b0, 37, ROW_BAD_RADIX);
		add_row(64'h8000_0000_0000_0000, 1'b1, 63, ROW_BAD_RADIX);
		add_row(64'hffff_ffff_ffff_ffff, 1'b0, 2, ROW_PREDICT);
		add_row(64'h8000_0000_0000_0000, 1'b1, 2, ROW_PREDICT);
		add_row(64'h8000_0000_0000_0000, 1'b0, 2, ROW_PREDICT);
		add_row(64'hffff_ffff_ffff_ffff, 1'b0, 36, ROW_PREDICT);
		add_row(64'd12345, 1'b0, 8, ROW_PREDICT);
		add_row(64'hdead_beef_0123_4567, 1'b1, 7, ROW_PREDICT);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i]);
		drain_results();

		// Random numbers; a long stretch in the middle runs without gaps
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = !(n >= 150 && n < 260);
			if (n % 120 == 60)
				drain_results();
			row.val  = rand_value();
			row.sgn  = 1'($urandom_range(0, 1));
			row.rdx  = rand_radix();
			row.kind = ROW_PREDICT;
			row.text = "";
			send_item(row);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && digits_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Stop a hung run
	initial begin
		#6000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> integer_to_radix_text.f
+incdir+sv
sv/r2t_pkg.sv
sv/r2t_feed.sv
sv/r2t_digit_row.sv
sv/integer_to_radix_text.sv
dv/tb.sv
